// ===== hdl/sli_pkg.sv =====
// shared constants, codes and types for the sorted list core
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OP_W     = 2;
  localparam int POS_W    = 4;
  localparam int HELD_W   = 5;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef logic signed [VAL_W-1:0] entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t key;
  } cmd_t;

endpackage

// ===== hdl/sli_req_if.sv =====
// request and response channel interfaces of the sorted list core
interface sli_req_if;
  logic                          valid;
  logic                          ready;
  logic [sli_pkg::OP_W-1:0]      op;
  logic signed [sli_pkg::VAL_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface sli_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [sli_pkg::POS_W-1:0]     position;
  logic [sli_pkg::HELD_W-1:0]    entries_held;
  logic [sli_pkg::STAT_W-1:0]    status;

  modport source (output valid, output found, output position, output entries_held,
                  output status, input ready);
  modport sink   (input valid, input found, input position, input entries_held,
                  input status, output ready);
endinterface

// ===== hdl/sli_cell.sv =====
// one list cell: holds an entry, compares it to the key, shifts with its neighbors
module sli_cell (
  input  logic            clk,
  input  sli_pkg::cmd_t   cmd,
  input  logic            valid,
  input  logic            left_lt,
  input  sli_pkg::entry_t left_entry,
  input  sli_pkg::entry_t right_entry,
  output sli_pkg::entry_t entry,
  output logic            lt,
  output logic            hit,
  output logic            eq
);

  sli_pkg::entry_t entry_r;
  sli_pkg::entry_t entry_nxt;

  assign entry = entry_r;
  assign lt    = valid & (entry_r < cmd.key);
  assign hit   = left_lt & ~lt;
  assign eq    = valid & (entry_r == cmd.key);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins && !lt) begin
      entry_nxt = left_lt ? cmd.key : left_entry;
    end else if (cmd.rem && !lt) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hdl/sorted_list_insert_find_remove_core.sv =====
// top level of the sorted list core: request register, cell chain and result register
// a request waits in the request register, passes the cell chain, and its result word is registered
// throughput: one request per cycle while results are taken; each request is one
//   pass of the cell chain (compare, locate, shift)
// reset: rst_n synchronous active low; empties the list and clears pending words,
//   cell contents are not reset
module sorted_list_insert_find_remove_core (
  input  logic      clk,
  input  logic      rst_n,
  sli_req_if.sink   in_req,
  sli_rsp_if.source out_rsp
);

  localparam int N = sli_pkg::CAPACITY;

  logic                        req_v_r;
  logic                        req_v_nxt;
  logic [sli_pkg::OP_W-1:0]    req_op_r;
  sli_pkg::entry_t             req_key_r;
  logic [sli_pkg::CNT_W-1:0]   count_r;
  logic [sli_pkg::CNT_W-1:0]   count_nxt;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        found_r;
  logic [sli_pkg::POS_W-1:0]   position_r;
  logic [sli_pkg::HELD_W-1:0]  held_r;
  logic [sli_pkg::STAT_W-1:0]  status_r;

  logic                        exec;
  logic                        accept;
  logic                        full;
  logic                        found;
  logic                        do_ins;
  logic                        do_rem;
  logic [sli_pkg::IDX_W-1:0]   pos_idx;
  logic [sli_pkg::POS_W-1:0]   pos_out;
  logic [sli_pkg::STAT_W-1:0]  status_nxt;
  sli_pkg::cmd_t               cmd;

  sli_pkg::entry_t             entry [N];
  logic [N-1:0]                valid;
  logic [N-1:0]                lt;
  logic [N-1:0]                hit;
  logic [N-1:0]                eq;

  assign exec   = req_v_r & (~out_valid_r | out_rsp.ready);
  assign in_req.ready = ~req_v_r | exec;
  assign accept = in_req.valid & in_req.ready;
  assign full   = (count_r == sli_pkg::CNT_W'(N));
  assign found  = |(hit & eq);
  assign do_ins = exec & (req_op_r == sli_pkg::OP_INSERT) & ~full;
  assign do_rem = exec & (req_op_r == sli_pkg::OP_REMOVE) & found;

  assign cmd.ins = do_ins;
  assign cmd.rem = do_rem;
  assign cmd.key = req_key_r;

  // cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic            left_lt;
    sli_pkg::entry_t left_entry;
    sli_pkg::entry_t right_entry;

    assign valid[i] = (count_r > sli_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = req_key_r;
    end else begin : g_mid
      assign left_lt    = lt[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_body
      assign right_entry = entry[i+1];
    end

    sli_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .valid       (valid[i]),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[i]),
      .lt          (lt[i]),
      .hit         (hit[i]),
      .eq          (eq[i])
    );
  end

  // at most one cell sees the boundary, so an or of indexes encodes it
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (hit[i]) begin
        pos_idx = pos_idx | sli_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = sli_pkg::STAT_OK;
    pos_out    = '0;
    unique case (req_op_r)
      sli_pkg::OP_INSERT: begin
        if (full) begin
          status_nxt = sli_pkg::STAT_FULL;
        end else begin
          pos_out = sli_pkg::POS_W'(pos_idx);
        end
      end
      sli_pkg::OP_FIND, sli_pkg::OP_REMOVE: begin
        if (found) begin
          pos_out = sli_pkg::POS_W'(pos_idx);
        end else begin
          status_nxt = sli_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        status_nxt = sli_pkg::STAT_OK;
      end
    endcase
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign req_v_nxt     = accept | (req_v_r & ~exec);
  assign out_valid_nxt = exec | (out_valid_r & ~out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      req_v_r     <= req_v_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r  <= in_req.op;
      req_key_r <= in_req.value;
    end
    if (exec) begin
      found_r    <= found & ((req_op_r == sli_pkg::OP_FIND) |
                             (req_op_r == sli_pkg::OP_REMOVE));
      position_r <= pos_out;
      held_r     <= sli_pkg::HELD_W'(count_nxt);
      status_r   <= status_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.found        = found_r;
  assign out_rsp.position     = position_r;
  assign out_rsp.entries_held = held_r;
  assign out_rsp.status       = status_r;

endmodule
